FILE: src/toeq_pkg.sv
// Time-ordered event queue: shared types, codes and constants.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package toeq_pkg;

  localparam int unsigned DEPTH_DEFAULT = 64;
  localparam int unsigned TIME_W        = 32;
  localparam int unsigned KIND_W        = 3;
  localparam int unsigned TAG_W         = 16;
  localparam int unsigned MODE_W        = 2;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned OCC_W         = 7;

  // kind code searched for by a query (signal opening)
  localparam logic [KIND_W-1:0] KIND_OPENING = KIND_W'(1);

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_POP    = 2'd1,
    MODE_QUERY  = 2'd2,
    MODE_NOP    = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_e;

  // what every cell of the chain does in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_POP    = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_e;

  typedef struct packed {
    logic [TIME_W-1:0] evt_time;
    logic [KIND_W-1:0] kind;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  // broadcast from the controller to all cells
  typedef struct packed {
    cell_op_e op;
    entry_t   new_entry;
    entry_t   head_entry;
  } cell_ctl_t;

endpackage

FILE: src/toeq_in_if.sv
// Operation channel of the event queue: valid/ready plus one operation beat.
// Depends on toeq_pkg.
`timescale 1ns / 1ps

interface toeq_in_if;
  import toeq_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [TIME_W-1:0] event_time;
  logic [KIND_W-1:0] event_kind;
  logic [TAG_W-1:0]  event_tag;
  logic [TIME_W-1:0] query_time;

  modport source (
    output valid, mode, event_time, event_kind, event_tag, query_time,
    input  ready
  );

  modport sink (
    input  valid, mode, event_time, event_kind, event_tag, query_time,
    output ready
  );
endinterface

FILE: src/toeq_out_if.sv
// Result channel of the event queue: valid/ready plus one result beat.
// Depends on toeq_pkg.
`timescale 1ns / 1ps

interface toeq_out_if;
  import toeq_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [TIME_W-1:0]   out_time;
  logic [KIND_W-1:0]   out_kind;
  logic [TAG_W-1:0]    out_tag;
  logic [OCC_W-1:0]    occupancy;

  modport source (
    output valid, status, out_time, out_kind, out_tag, occupancy,
    input  ready
  );

  modport sink (
    input  valid, status, out_time, out_kind, out_tag, occupancy,
    output ready
  );
endinterface

FILE: src/toeq_cell.sv
// One slot of the sorted event chain: holds an entry, compares on insert,
// shifts with its neighbors on insert, pop and rotate. Depends on toeq_pkg.
`timescale 1ns / 1ps

module toeq_cell #(
  parameter int unsigned QUEUE_DEPTH = toeq_pkg::DEPTH_DEFAULT,
  parameter int unsigned INDEX       = 0
) (
  input  logic                               clk,
  input  toeq_pkg::cell_ctl_t                ctl,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0]   count,
  input  logic                               left_take,
  input  toeq_pkg::entry_t                   left_entry,
  input  toeq_pkg::entry_t                   right_entry,
  output logic                               take,
  output toeq_pkg::entry_t                   entry_q
);
  import toeq_pkg::*;

  localparam int unsigned CW = $clog2(QUEUE_DEPTH+1);

  entry_t entry_r;
  entry_t entry_nxt;
  logic   occupied;
  logic   is_last;

  // slot position against the fill count
  assign occupied = CW'(INDEX) < count;
  assign is_last  = CW'(INDEX) == (count - CW'(1));

  // new event lands at the first slot that is free or holds a time not smaller than it
  assign take = !occupied || (ctl.new_entry.evt_time <= entry_r.evt_time);

  always_comb begin
    entry_nxt = entry_r;
    unique case (ctl.op)
      CELL_HOLD:   entry_nxt = entry_r;
      CELL_INSERT: begin
        if (left_take) begin
          entry_nxt = left_entry;
        end else if (take) begin
          entry_nxt = ctl.new_entry;
        end
      end
      CELL_POP:    entry_nxt = right_entry;
      // last used slot wraps the head around
      CELL_ROTATE: entry_nxt = is_last ? ctl.head_entry : right_entry;
      default:     entry_nxt = entry_r;
    endcase
  end

  // payload only, no reset
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_q = entry_r;

endmodule

FILE: src/time_ordered_event_queue.sv
// Top level of the time-ordered event queue: controller, result register
// and the chain of toeq_cell slots. Depends on toeq_pkg, toeq_in_if, toeq_out_if.
`timescale 1ns / 1ps
//
//  channel   modport             beat carries
//  --------  ------------------  ---------------------------------------------------
//  in_ch     toeq_in_if.sink     mode, event_time, event_kind, event_tag, query_time
//  out_ch    toeq_out_if.source  status, out_time, out_kind, out_tag, occupancy
//
//  Insert and pop shift the whole chain at once; the unused mode leaves it as it is.
//  A query on a non-empty queue is accepted, then the chain rotates each entry in turn
//  through the head comparator, so the entries come back in order at the end.
//  A query on an empty queue returns its not-found result without a scan.
//  Synchronous active-low reset clears the count and control; slot contents are
//  not cleared, slots at or beyond the count are never read.
//  The block takes a new beat only when idle and the result register is free
//  or being emptied in the same cycle; a stalled result holds its beat.

module time_ordered_event_queue #(
  parameter int unsigned QUEUE_DEPTH = toeq_pkg::DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst_n,
  toeq_in_if.sink    in_ch,
  toeq_out_if.source out_ch
);
  import toeq_pkg::*;

  localparam int unsigned CW = $clog2(QUEUE_DEPTH+1);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  state_t            state_r;
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     scan_idx_r;
  logic [TIME_W-1:0] query_r;
  logic              found_r;
  entry_t            hit_r;

  logic              out_valid_r;
  status_e           out_status_r;
  entry_t            out_entry_r;
  logic [OCC_W-1:0]  out_occ_r;

  entry_t            cell_q [QUEUE_DEPTH];
  logic              take   [QUEUE_DEPTH];
  cell_ctl_t         ctl;
  entry_t            head;
  entry_t            in_entry;
  mode_e             in_mode;
  logic              in_fire;
  logic              is_full;
  logic              is_empty;
  logic              scan_last;
  logic              head_match;

  assign head     = cell_q[0];
  assign in_mode  = mode_e'(in_ch.mode);
  assign in_entry = '{evt_time: in_ch.event_time, kind: in_ch.event_kind,
                      tag: in_ch.event_tag};

  assign in_ch.ready = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign is_full    = count_r == CW'(QUEUE_DEPTH);
  assign is_empty   = count_r == '0;
  assign scan_last  = scan_idx_r == (count_r - CW'(1));
  assign head_match = (head.kind == KIND_OPENING) && (head.evt_time > query_r);

  // chain command for this cycle
  always_comb begin
    ctl.new_entry  = in_entry;
    ctl.head_entry = head;
    ctl.op         = CELL_HOLD;
    priority if (state_r == ST_SCAN) begin
      ctl.op = CELL_ROTATE;
    end else if (in_fire) begin
      unique case (in_mode)
        MODE_INSERT: ctl.op = is_full  ? CELL_HOLD : CELL_INSERT;
        MODE_POP:    ctl.op = is_empty ? CELL_HOLD : CELL_POP;
        MODE_QUERY:  ctl.op = CELL_HOLD;
        MODE_NOP:    ctl.op = CELL_HOLD;
        default:     ctl.op = CELL_HOLD;
      endcase
    end else begin
      ctl.op = CELL_HOLD;
    end
  end

  // chain of slots, head at index 0
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic   left_take;
    entry_t left_entry;
    entry_t right_entry;

    if (g == 0) begin : g_first
      assign left_take  = 1'b0;
      assign left_entry = '0;
    end else begin : g_mid
      assign left_take  = take[g-1];
      assign left_entry = cell_q[g-1];
    end

    if (g == QUEUE_DEPTH - 1) begin : g_end
      assign right_entry = '0;
    end else begin : g_inner
      assign right_entry = cell_q[g+1];
    end

    toeq_cell #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .INDEX       (g)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .count       (count_r),
      .left_take   (left_take),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .take        (take[g]),
      .entry_q     (cell_q[g])
    );
  end

  // controller and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      scan_idx_r  <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            out_valid_r  <= 1'b1;
            out_status_r <= STAT_OK;
            out_entry_r  <= '0;
            out_occ_r    <= OCC_W'(count_r);
            unique case (in_mode)
              MODE_INSERT: begin
                if (is_full) begin
                  out_status_r <= STAT_FULL;
                end else begin
                  count_r   <= count_r + CW'(1);
                  out_occ_r <= OCC_W'(count_r + CW'(1));
                end
              end
              MODE_POP: begin
                if (is_empty) begin
                  out_status_r <= STAT_EMPTY;
                end else begin
                  count_r     <= count_r - CW'(1);
                  out_entry_r <= head;
                  out_occ_r   <= OCC_W'(count_r - CW'(1));
                end
              end
              MODE_QUERY: begin
                if (is_empty) begin
                  out_status_r <= STAT_NOT_FOUND;
                end else begin
                  // result comes after one full rotation
                  out_valid_r <= 1'b0;
                  state_r     <= ST_SCAN;
                  scan_idx_r  <= '0;
                  found_r     <= 1'b0;
                  query_r     <= in_ch.query_time;
                end
              end
              MODE_NOP: begin
                out_status_r <= STAT_OK;
              end
              default: begin
                out_status_r <= STAT_OK;
              end
            endcase
          end
        end

        ST_SCAN: begin
          // first match along the sorted order wins
          if (!found_r && head_match) begin
            found_r <= 1'b1;
            hit_r   <= head;
          end
          scan_idx_r <= scan_idx_r + CW'(1);
          if (scan_last) begin
            state_r     <= ST_IDLE;
            out_valid_r <= 1'b1;
            out_occ_r   <= OCC_W'(count_r);
            if (found_r) begin
              out_status_r <= STAT_OK;
              out_entry_r  <= hit_r;
            end else if (head_match) begin
              out_status_r <= STAT_OK;
              out_entry_r  <= head;
            end else begin
              out_status_r <= STAT_NOT_FOUND;
              out_entry_r  <= '0;
            end
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.out_time  = out_entry_r.evt_time;
  assign out_ch.out_kind  = out_entry_r.kind;
  assign out_ch.out_tag   = out_entry_r.tag;
  assign out_ch.occupancy = out_occ_r;

endmodule

FILE: src/toeq_checker.sv
// Port-level checks for the time-ordered event queue, bound to the top level.
// Depends on toeq_pkg and time_ordered_event_queue.
`timescale 1ns / 1ps

module toeq_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [toeq_pkg::STATUS_W-1:0] out_status,
  input logic [toeq_pkg::TIME_W-1:0]   out_time,
  input logic [toeq_pkg::KIND_W-1:0]   out_kind,
  input logic [toeq_pkg::TAG_W-1:0]    out_tag,
  input logic [toeq_pkg::OCC_W-1:0]    out_occupancy
);
  import toeq_pkg::*;

  // a stalled result beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_time) && $stable(out_kind) && $stable(out_tag)
      && $stable(out_occupancy))
    else $error("result beat changed while stalled");

  // no new operation while the result register is blocked
  a_no_take_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("operation accepted while result stalled");

  // failed operations carry no event
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STAT_OK) |->
      (out_time == '0) && (out_kind == '0) && (out_tag == '0))
    else $error("non-ok result with event payload");

  // pop on empty leaves nothing stored
  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_EMPTY) |-> out_occupancy == '0)
    else $error("empty status with nonzero occupancy");

endmodule

bind time_ordered_event_queue toeq_checker u_toeq_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_status    (out_ch.status),
  .out_time      (out_ch.out_time),
  .out_kind      (out_ch.out_kind),
  .out_tag       (out_ch.out_tag),
  .out_occupancy (out_ch.occupancy)
);
